// ===== hw/rtl/mlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared constants and operation codes of the linked list manager.
// ----------------------------------------------------------------------------
package mlc_pkg;

	localparam int DEF_MAX_LISTS  = 16;
	localparam int DEF_POOL_SIZE  = 1024;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int OP_WIDTH       = 3;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_CREATE  = 3'd0,
		OP_APPEND  = 3'd1,
		OP_REWIND  = 3'd2,
		OP_READ    = 3'd3,
		OP_ADVANCE = 3'd4,
		OP_DELETE  = 3'd5,
		OP_DESTROY = 3'd6
	} op_t;

endpackage

// ===== hw/rtl/mlc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlc_cmd_if / mlc_rsp_if
// Valid/ready channels for commands and responses.
// ----------------------------------------------------------------------------
interface mlc_cmd_if #(
	parameter int HW = 5,
	parameter int DW = 32
);
	logic                         valid;
	logic                         ready;
	logic [mlc_pkg::OP_WIDTH-1:0] op;
	logic [HW-1:0]                list_id;
	logic [DW-1:0]                item_data;

	modport source (output valid, op, list_id, item_data, input ready);
	modport sink (input valid, op, list_id, item_data, output ready);
endinterface

interface mlc_rsp_if #(
	parameter int HW = 5,
	parameter int DW = 32
);
	logic          valid;
	logic          ready;
	logic          ok;
	logic [HW-1:0] new_handle;
	logic [DW-1:0] read_data;

	modport source (output valid, ok, new_handle, read_data, input ready);
	modport sink (input valid, ok, new_handle, read_data, output ready);
endinterface

// ===== hw/rtl/mlc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlc_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlc_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/multi_list_cursor_manager_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_list_cursor_manager_unit
// Doubly linked lists with cursors over a shared element pool.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries op, list_id and item_data; a transfer happens when valid
//   and ready are high at a clock edge. rsp returns one result per command
//   (ok, new_handle, read_data) in command order.
//   One command is worked on at a time. From accept it passes S_EXEC, then
//   as the operation needs S_RD, S_APP and S_W2, and S_RESP loads the result
//   into the output register. Read, advance, delete and append from the free
//   list need S_RD for the registered reads of the link and data memories;
//   the next-link memory has a single write port (delete and append may
//   write it twice, append from the free list first reads it), hence S_W2.
//   A finished result waits in the output register; the next command is
//   accepted meanwhile and only its completion waits for rsp to drain.
//   Reset clears the list slot flags, the free list and the fresh pool
//   counter at once; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module multi_list_cursor_manager_unit #(
	parameter int MAX_LISTS  = mlc_pkg::DEF_MAX_LISTS,
	parameter int POOL_SIZE  = mlc_pkg::DEF_POOL_SIZE,
	parameter int DATA_WIDTH = mlc_pkg::DEF_DATA_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	mlc_cmd_if.sink   cmd,
	mlc_rsp_if.source rsp
);
	import mlc_pkg::*;

	localparam int HW = $clog2(MAX_LISTS + 1);
	localparam int SW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
	localparam int PW = $clog2(POOL_SIZE + 1);
	localparam int AW = $clog2(POOL_SIZE);
	localparam logic [PW-1:0] NONE = PW'(POOL_SIZE);

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_RD, S_APP, S_W2, S_RESP} state_t;

	state_t                state_q, state_d;
	logic [OP_WIDTH-1:0]   op_q, op_d;
	logic [HW-1:0]         handle_q, handle_d;
	logic [DATA_WIDTH-1:0] data_q, data_d;
	logic [PW-1:0]         e_q, e_d, aux_q, aux_d;
	logic [PW-1:0]         free_head_q, free_head_d, fresh_q, fresh_d;
	logic [MAX_LISTS-1:0]  used_q, used_d;
	logic                  res_ok_q, res_ok_d;
	logic [HW-1:0]         res_nh_q, res_nh_d;
	logic [DATA_WIDTH-1:0] res_rd_q, res_rd_d;
	logic                  out_v_q, out_v_d, out_ok_q, out_ok_d;
	logic [HW-1:0]         out_nh_q, out_nh_d;
	logic [DATA_WIDTH-1:0] out_rd_q, out_rd_d;

	// list table, no reset: written by create before use
	logic [PW-1:0] head_q [MAX_LISTS];
	logic [PW-1:0] tail_q [MAX_LISTS];
	logic [PW-1:0] cur_q  [MAX_LISTS];
	logic          head_we, tail_we, cur_we;
	logic [PW-1:0] head_wd, tail_wd, cur_wd;
	logic [SW-1:0] tbl_idx;

	// memory ports
	logic                  nxt_we, prv_we, dat_we;
	logic [AW-1:0]         nxt_wa, prv_wa, dat_wa, nxt_ra, prv_ra, dat_ra;
	logic [PW-1:0]         nxt_wd, prv_wd, nxt_rd, prv_rd;
	logic [DATA_WIDTH-1:0] dat_wd, dat_rd;

	// handle decode
	logic [SW-1:0] sidx;
	logic          hv;
	logic [PW-1:0] head_s, tail_s, cur_s;
	logic          found;
	logic [SW-1:0] fidx;

	assign sidx   = SW'(handle_q - HW'(1));
	assign hv     = (handle_q != '0) && (handle_q <= HW'(MAX_LISTS)) && used_q[sidx];
	assign head_s = head_q[sidx];
	assign tail_s = tail_q[sidx];
	assign cur_s  = cur_q[sidx];

	// lowest free list slot
	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int i = MAX_LISTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				found = 1'b1;
				fidx  = SW'(i);
			end
		end
	end

	mlc_ram #(.DEPTH(POOL_SIZE), .WIDTH(PW)) u_next_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd)
	);
	mlc_ram #(.DEPTH(POOL_SIZE), .WIDTH(PW)) u_prev_ram (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(prv_ra), .rdata(prv_rd)
	);
	mlc_ram #(.DEPTH(POOL_SIZE), .WIDTH(DATA_WIDTH)) u_data_ram (
		.clk(clk), .we(dat_we), .waddr(dat_wa), .wdata(dat_wd), .raddr(dat_ra), .rdata(dat_rd)
	);

	assign cmd.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_v_q;
	assign rsp.ok         = out_ok_q;
	assign rsp.new_handle = out_nh_q;
	assign rsp.read_data  = out_rd_q;

	// operation sequencer
	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		handle_d    = handle_q;
		data_d      = data_q;
		e_d         = e_q;
		aux_d       = aux_q;
		free_head_d = free_head_q;
		fresh_d     = fresh_q;
		used_d      = used_q;
		res_ok_d    = res_ok_q;
		res_nh_d    = res_nh_q;
		res_rd_d    = res_rd_q;
		out_v_d     = out_v_q && !rsp.ready;
		out_ok_d    = out_ok_q;
		out_nh_d    = out_nh_q;
		out_rd_d    = out_rd_q;
		tbl_idx     = sidx;
		head_we     = 1'b0;
		tail_we     = 1'b0;
		cur_we      = 1'b0;
		head_wd     = NONE;
		tail_wd     = NONE;
		cur_wd      = NONE;
		nxt_we      = 1'b0;
		prv_we      = 1'b0;
		dat_we      = 1'b0;
		nxt_wa      = e_q[AW-1:0];
		prv_wa      = e_q[AW-1:0];
		dat_wa      = e_q[AW-1:0];
		nxt_wd      = NONE;
		prv_wd      = tail_s;
		dat_wd      = data_q;
		nxt_ra      = cur_s[AW-1:0];
		prv_ra      = cur_s[AW-1:0];
		dat_ra      = cur_s[AW-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					op_d     = cmd.op;
					handle_d = cmd.list_id;
					data_d   = cmd.item_data;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				res_ok_d = 1'b0;
				res_nh_d = '0;
				res_rd_d = '0;
				state_d  = S_RESP;
				case (op_q) inside
					OP_CREATE: begin
						if (found) begin
							used_d[fidx] = 1'b1;
							tbl_idx      = fidx;
							head_we      = 1'b1;
							tail_we      = 1'b1;
							cur_we       = 1'b1;
							res_ok_d     = 1'b1;
							res_nh_d     = HW'(fidx) + HW'(1);
						end
					end
					OP_APPEND: begin
						if (hv && free_head_q != NONE) begin
							nxt_ra  = free_head_q[AW-1:0];
							e_d     = free_head_q;
							state_d = S_RD;
						end else if (hv && fresh_q != NONE) begin
							e_d     = fresh_q;
							fresh_d = fresh_q + PW'(1);
							state_d = S_APP;
						end
					end
					OP_REWIND: begin
						if (hv) begin
							cur_we   = 1'b1;
							cur_wd   = head_s;
							res_ok_d = 1'b1;
						end
					end
					OP_READ, OP_ADVANCE: begin
						if (hv && cur_s != NONE) begin
							state_d = S_RD;
						end
					end
					OP_DELETE: begin
						if (hv && cur_s != NONE) begin
							e_d     = cur_s;
							state_d = S_RD;
						end
					end
					OP_DESTROY: begin
						if (hv) begin
							if (head_s != NONE && tail_s != NONE) begin
								nxt_we      = 1'b1;
								nxt_wa      = tail_s[AW-1:0];
								nxt_wd      = free_head_q;
								free_head_d = head_s;
							end
							used_d[sidx] = 1'b0;
							res_ok_d     = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_RD: begin
				state_d = S_RESP;
				case (op_q)
					OP_APPEND: begin
						free_head_d = nxt_rd;
						state_d     = S_APP;
					end
					OP_READ: begin
						res_ok_d = 1'b1;
						res_rd_d = dat_rd;
					end
					OP_ADVANCE: begin
						cur_we   = 1'b1;
						cur_wd   = nxt_rd;
						res_ok_d = (nxt_rd != NONE);
					end
					OP_DELETE: begin
						// unlink: neighbors point past the element
						if (prv_rd != NONE) begin
							nxt_we = 1'b1;
							nxt_wa = prv_rd[AW-1:0];
							nxt_wd = nxt_rd;
						end else begin
							head_we = 1'b1;
							head_wd = nxt_rd;
						end
						if (nxt_rd != NONE) begin
							prv_we = 1'b1;
							prv_wa = nxt_rd[AW-1:0];
							prv_wd = prv_rd;
						end else begin
							tail_we = 1'b1;
							tail_wd = prv_rd;
						end
						cur_we  = 1'b1;
						cur_wd  = nxt_rd;
						state_d = S_W2;
					end
					default: ;
				endcase
			end
			S_APP: begin
				// new element at the tail
				dat_we   = 1'b1;
				prv_we   = 1'b1;
				nxt_we   = 1'b1;
				tail_we  = 1'b1;
				tail_wd  = e_q;
				aux_d    = tail_s;
				res_ok_d = 1'b1;
				if (tail_s != NONE) begin
					state_d = S_W2;
				end else begin
					head_we = 1'b1;
					head_wd = e_q;
					state_d = S_RESP;
				end
			end
			S_W2: begin
				nxt_we = 1'b1;
				if (op_q == OP_APPEND) begin
					nxt_wa = aux_q[AW-1:0];
					nxt_wd = e_q;
				end else begin
					// released element goes to the free list
					nxt_wd      = free_head_q;
					free_head_d = e_q;
				end
				res_ok_d = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (!out_v_q || rsp.ready) begin
					out_v_d  = 1'b1;
					out_ok_d = res_ok_q;
					out_nh_d = res_nh_q;
					out_rd_d = res_rd_q;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= NONE;
			fresh_q     <= '0;
			used_q      <= '0;
			out_v_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			free_head_q <= free_head_d;
			fresh_q     <= fresh_d;
			used_q      <= used_d;
			out_v_q     <= out_v_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		op_q     <= op_d;
		handle_q <= handle_d;
		data_q   <= data_d;
		e_q      <= e_d;
		aux_q    <= aux_d;
		res_ok_q <= res_ok_d;
		res_nh_q <= res_nh_d;
		res_rd_q <= res_rd_d;
		out_ok_q <= out_ok_d;
		out_nh_q <= out_nh_d;
		out_rd_q <= out_rd_d;
		if (head_we) begin
			head_q[tbl_idx] <= head_wd;
		end
		if (tail_we) begin
			tail_q[tbl_idx] <= tail_wd;
		end
		if (cur_we) begin
			cur_q[tbl_idx] <= cur_wd;
		end
	end

	// free list head is always an element or none
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= NONE)
		else $error("free list head out of range");

	// fresh counter never passes the pool size
	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NONE)
		else $error("fresh counter out of range");

	// a new response is only loaded from the response state
	a_rsp_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == S_RESP))
		else $error("response loaded outside response state");

	// a nonzero handle is only returned with success
	a_create_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && res_nh_q != '0) |-> res_ok_q)
		else $error("handle returned without success");

endmodule
